FILE: design/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/annexb_pkg.sv
// shared types and constants for the annex b nal splitter
// no dependencies; used by the channel interfaces and the top level
package annexb_pkg;

  localparam int BYTE_W          = 8;
  localparam int TYPE_W          = 5;
  localparam int LEN_W           = 24;
  localparam int LENGTH_BITS_DEF = 24;
  localparam int MAX_RES         = 5;
  localparam int RES_CNT_W       = 3;

  localparam logic [BYTE_W-1:0] TYPE_MASK  = 8'h1f;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE   = 8'h01;
  localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};

  typedef struct packed {
    logic                byte_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic                first_of_unit;
    logic                last_of_unit;
    logic [TYPE_W-1:0]   unit_type;
    logic [LEN_W-1:0]    unit_length;
    logic                run_last;
    logic                no_start_code;
  } res_t;

endpackage

FILE: design/annexb_in_if.sv
// input byte channel of the annex b nal splitter
// depends on annexb_pkg for field widths
interface annexb_in_if;
  import annexb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              unit_end;

  modport source(output valid, in_byte, unit_end, input ready);
  modport sink(input valid, in_byte, unit_end, output ready);
endinterface

FILE: design/annexb_out_if.sv
// result channel of the annex b nal splitter
// depends on annexb_pkg for field widths
interface annexb_out_if;
  import annexb_pkg::*;

  logic              valid;
  logic              ready;
  logic              byte_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              first_of_unit;
  logic              last_of_unit;
  logic [TYPE_W-1:0] unit_type;
  logic [LEN_W-1:0]  unit_length;
  logic              run_last;
  logic              no_start_code;

  modport source(output valid, byte_valid, out_byte, first_of_unit, last_of_unit,
                 unit_type, unit_length, run_last, no_start_code, input ready);
  modport sink(input valid, byte_valid, out_byte, first_of_unit, last_of_unit,
               unit_type, unit_length, run_last, no_start_code, output ready);
endinterface

FILE: design/annexb_nal_splitter.sv
// annex b start code splitter, top level
// depends on annexb_pkg, annexb_in_if, annexb_out_if and assert_macros.svh
//
// usage:
//   in_ch carries one byte of a decode unit per transfer, unit_end on its final
//   byte. out_ch carries payload bytes split at 00 00 01 / 00 00 00 01 start
//   codes, with first/last marks, the unit type and, on the last byte, the
//   saturating unit length. run_last marks the final result of one input byte;
//   a byte that closes a decode unit with nothing to emit gives one status
//   result (byte_valid low) carrying no_start_code.
// path: a result passes from its input transfer through the input register,
//   then the result buffer.
// throughput: one byte per cycle while each byte yields at most one result and
//   out_ch.ready stays high. A byte yielding more results (up to five) holds the
//   input stage until the five-entry result buffer drains, one entry per transfer.
// reset: rst_n low clears both stages and returns the parser to searching.
// stall: with out_ch.ready low the buffer holds its entries, the input register
//   fills, and in_ch.ready drops until the buffer can take the next byte.
module annexb_nal_splitter #(
  parameter int LENGTH_BITS = annexb_pkg::LENGTH_BITS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  annexb_in_if.sink      in_ch,
  annexb_out_if.source   out_ch
);
  import annexb_pkg::*;
  `include "assert_macros.svh"

  localparam int WIDE_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

  // input register
  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;

  // parser state
  logic                   inside_r;
  logic [1:0]             zr_r;
  logic                   hv_r;
  logic [BYTE_W-1:0]      held_byte_r;
  logic                   held_first_r;
  logic [TYPE_W-1:0]      cur_type_r;
  logic [LENGTH_BITS-1:0] bc_r;
  logic                   code_seen_r;

  // result buffer
  res_t                 buf_r [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_CNT_W-1:0] rd_idx_r;

  logic out_fire, buf_free, proc;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign buf_free = (rd_idx_r == cnt_r) ||
                    (out_fire && (rd_idx_r + RES_CNT_W'(1) == cnt_r));
  assign proc     = in_v_r && buf_free;
  assign in_ch.ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
      in_end_r  <= in_ch.unit_end;
    end
  end

  // parse step
  logic                   is_zero, is_one, found, case_b, case_c, case_d;
  logic                   m_h, end_act, e_h, missing;
  logic [1:0]             m_z, nzr, e_z;
  logic [RES_CNT_W-1:0]   mcnt, total, res_cnt_nxt;
  logic                   nh_v, nh_first;
  logic [BYTE_W-1:0]      nh_byte;
  logic [BYTE_W-1:0]      slot_byte [MAX_RES];
  logic                   slot_first [MAX_RES];
  logic [LENGTH_BITS-1:0] slot_cnt [MAX_RES];
  logic [LENGTH_BITS:0]   sum_tmp;
  logic [WIDE_W-1:0]      wide_cnt;
  logic [TYPE_W-1:0]      type_all;
  logic                   first0;
  res_t                   res_nxt [MAX_RES];

  logic                   inside_nxt, hv_nxt, held_first_nxt, code_seen_nxt;
  logic [1:0]             zr_nxt;
  logic [BYTE_W-1:0]      held_byte_nxt;
  logic [TYPE_W-1:0]      cur_type_nxt;
  logic [LENGTH_BITS-1:0] bc_nxt;

  always_comb begin
    is_zero = (in_byte_r == BYTE_ZERO);
    is_one  = (in_byte_r == BYTE_ONE);
    found   = !inside_r && is_one && zr_r[1];
    case_b  = inside_r && is_one && zr_r[1];
    case_c  = inside_r && is_zero;
    case_d  = inside_r && !is_zero && !case_b;

    m_h  = inside_r && hv_r && !(case_c && zr_r != 2'd3);
    m_z  = case_d ? zr_r : 2'd0;
    mcnt = RES_CNT_W'(m_h) + RES_CNT_W'(m_z);

    // held slot and pending zeros after the main part of the step
    nh_v     = hv_r;
    nh_byte  = held_byte_r;
    nh_first = held_first_r;
    nzr      = zr_r;
    if (!inside_r) begin
      if (found) begin
        nh_v = 1'b0;
        nzr  = 2'd0;
      end else if (is_zero) begin
        nzr = (zr_r == 2'd3) ? zr_r : zr_r + 2'd1;
      end else begin
        nzr = 2'd0;
      end
    end else if (case_b) begin
      nh_v = 1'b0;
      nzr  = 2'd0;
    end else if (case_c) begin
      if (zr_r != 2'd3) begin
        nzr = zr_r + 2'd1;
      end else begin
        nh_v     = 1'b1;
        nh_byte  = BYTE_ZERO;
        nh_first = (bc_r == '0) && !m_h;
      end
    end else begin
      nh_v     = 1'b1;
      nh_byte  = in_byte_r;
      nh_first = (bc_r == '0) && (mcnt == '0);
      nzr      = 2'd0;
    end

    // flush at decode unit end
    end_act = in_end_r && (inside_r || found) && !case_b;
    e_h     = end_act && nh_v;
    e_z     = end_act ? nzr : 2'd0;
    total   = mcnt + RES_CNT_W'(e_h) + RES_CNT_W'(e_z);
    missing = !(code_seen_r || found);
    res_cnt_nxt = (total == '0) ? RES_CNT_W'(in_end_r) : total;

    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < RES_CNT_W'(m_h)) begin
        slot_byte[k]  = held_byte_r;
        slot_first[k] = held_first_r;
      end else if (RES_CNT_W'(k) < mcnt + RES_CNT_W'(e_h) &&
                   RES_CNT_W'(k) >= mcnt) begin
        slot_byte[k]  = nh_byte;
        slot_first[k] = nh_first;
      end else begin
        slot_byte[k]  = BYTE_ZERO;
        slot_first[k] = (k == 0) && (bc_r == '0);
      end
      sum_tmp = {1'b0, bc_r} + (LENGTH_BITS+1)'(k + 1);
      slot_cnt[k] = (sum_tmp > {1'b0, CNT_MAX}) ? CNT_MAX : sum_tmp[LENGTH_BITS-1:0];
    end

    // a first mark can only land on the first result of a step
    first0   = (total != '0) && slot_first[0];
    type_all = first0 ? slot_byte[0][TYPE_W-1:0] & TYPE_MASK[TYPE_W-1:0] : cur_type_r;

    for (int k = 0; k < MAX_RES; k++) begin
      wide_cnt = WIDE_W'(slot_cnt[k]);
      res_nxt[k].byte_valid    = 1'b1;
      res_nxt[k].out_byte      = slot_byte[k];
      res_nxt[k].first_of_unit = slot_first[k];
      res_nxt[k].last_of_unit  = (RES_CNT_W'(k) == total - RES_CNT_W'(1)) &&
                                 (case_b || end_act);
      res_nxt[k].unit_type     = type_all;
      res_nxt[k].unit_length   = res_nxt[k].last_of_unit ?
                                 ((wide_cnt > WIDE_W'(LEN_MAX)) ? LEN_MAX
                                                                : wide_cnt[LEN_W-1:0])
                                 : '0;
      res_nxt[k].run_last      = (RES_CNT_W'(k) == total - RES_CNT_W'(1));
      res_nxt[k].no_start_code = res_nxt[k].run_last && in_end_r && missing;
    end
    if (total == '0) begin
      res_nxt[0]               = '0;
      res_nxt[0].run_last      = 1'b1;
      res_nxt[0].no_start_code = missing;
    end

    // next parser state
    if (in_end_r) begin
      inside_nxt     = 1'b0;
      code_seen_nxt  = 1'b0;
      zr_nxt         = 2'd0;
      hv_nxt         = 1'b0;
      held_byte_nxt  = BYTE_ZERO;
      held_first_nxt = 1'b0;
      cur_type_nxt   = '0;
      bc_nxt         = '0;
    end else begin
      inside_nxt     = inside_r || found;
      code_seen_nxt  = code_seen_r || found;
      zr_nxt         = nzr;
      hv_nxt         = nh_v;
      held_byte_nxt  = (found || case_b) ? BYTE_ZERO : nh_byte;
      held_first_nxt = (found || case_b) ? 1'b0 : nh_first;
      if (found || case_b) begin
        cur_type_nxt = '0;
        bc_nxt       = '0;
      end else begin
        cur_type_nxt = type_all;
        bc_nxt       = (mcnt == '0) ? bc_r : slot_cnt[mcnt - RES_CNT_W'(1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      zr_r         <= 2'd0;
      hv_r         <= 1'b0;
      held_byte_r  <= BYTE_ZERO;
      held_first_r <= 1'b0;
      cur_type_r   <= '0;
      bc_r         <= '0;
      code_seen_r  <= 1'b0;
    end else if (proc) begin
      inside_r     <= inside_nxt;
      zr_r         <= zr_nxt;
      hv_r         <= hv_nxt;
      held_byte_r  <= held_byte_nxt;
      held_first_r <= held_first_nxt;
      cur_type_r   <= cur_type_nxt;
      bc_r         <= bc_nxt;
      code_seen_r  <= code_seen_nxt;
    end
  end

  // result buffer: loaded whole, drained one entry per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else if (proc) begin
      cnt_r    <= res_cnt_nxt;
      rd_idx_r <= '0;
    end else if (out_fire) begin
      rd_idx_r <= rd_idx_r + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int k = 0; k < MAX_RES; k++) begin
        buf_r[k] <= res_nxt[k];
      end
    end
  end

  res_t cur_res;
  assign cur_res = buf_r[rd_idx_r];

  assign out_ch.valid         = (rd_idx_r != cnt_r);
  assign out_ch.byte_valid    = cur_res.byte_valid;
  assign out_ch.out_byte      = cur_res.out_byte;
  assign out_ch.first_of_unit = cur_res.first_of_unit;
  assign out_ch.last_of_unit  = cur_res.last_of_unit;
  assign out_ch.unit_type     = cur_res.unit_type;
  assign out_ch.unit_length   = cur_res.unit_length;
  assign out_ch.run_last      = cur_res.run_last;
  assign out_ch.no_start_code = cur_res.no_start_code;

  `ASSERT_CLK(a_idx_in_range, rd_idx_r <= cnt_r && cnt_r <= RES_CNT_W'(MAX_RES),
              "result buffer index out of range")
  `ASSERT_CLK(a_run_last_at_tail,
              !out_ch.valid || (out_ch.run_last == (rd_idx_r + RES_CNT_W'(1) == cnt_r)),
              "run_last not on the final buffered result")
  `ASSERT_NEXT(a_stalled_input_holds, in_v_r && !proc,
               in_v_r && $stable(in_byte_r) && $stable(in_end_r),
               "input register changed while waiting for the buffer")
  `ASSERT_NEXT(a_end_resets_parser, proc && in_end_r,
               !inside_r && !code_seen_r && !hv_r && zr_r == 2'd0,
               "parser state not cleared after decode unit end")
endmodule
